// ===== hdl/sad_disp_pkg.sv =====
// ----------------------------------------------------------------------------
// sad_disp_pkg
// Shared types and constants of the stereo SAD disparity block.
// ----------------------------------------------------------------------------
`default_nettype none

package sad_disp_pkg;

    localparam int PIX_W    = 32;
    localparam int DISP_W   = 6;
    localparam int COST_W   = 19;
    localparam int POS_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd4;

    localparam logic [11:0] RST_WIDTH    = 12'd640;
    localparam logic [11:0] RST_HEIGHT   = 12'd480;
    localparam logic [3:0]  RST_RADIUS   = 4'd2;
    localparam logic [5:0]  RST_DISP     = 6'd5;
    localparam logic [2:0]  RST_CHANNELS = 3'd4;

    localparam int MAX_HEIGHT = 2048;

    typedef struct packed {
        logic accept;
        logic issue;
        logic load_out;
    } sad_cmd_t;

    typedef struct packed {
        logic need_result;
        logic issue_last;
        logic done;
        logic out_free;
    } sad_status_t;

endpackage

`default_nettype wire

// ===== hdl/sad_disp_if.sv =====
// ----------------------------------------------------------------------------
// sad_disp_if
// Valid/ready channel interfaces: pixel input, result output, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sad_disp_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_pixel;
    logic [31:0] right_pixel;
    logic        frame_start;
    modport source (output valid, left_pixel, right_pixel, frame_start, input ready);
    modport sink   (input valid, left_pixel, right_pixel, frame_start, output ready);
endinterface

interface sad_disp_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  disparity;
    logic [18:0] match_cost;
    logic [10:0] column;
    logic [10:0] row;
    logic        frame_last;
    modport source (output valid, disparity, match_cost, column, row, frame_last,
                    input ready);
    modport sink   (input valid, disparity, match_cost, column, row, frame_last,
                    output ready);
endinterface

interface sad_disp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/stereo_sad_disparity.sv =====
// ----------------------------------------------------------------------------
// stereo_sad_disparity
// SAD block matching stereo disparity over a window kept in line stores.
// ----------------------------------------------------------------------------
// a pixel with no result is taken while idle; one with a result starts a scan of
// max_disparity * (2*radius+1)^2 window pixels, one window pixel per cycle from
// the line store read ports, and no new pixel is taken until the result sits in an output register
// reset clears the raster position and loads the default register values;
// line stores are not cleared
`default_nettype none

module stereo_sad_disparity #(
    parameter int MAX_WIDTH     = 2048,
    parameter int MAX_RADIUS    = 10,
    parameter int MAX_DISPARITY = 64,
    parameter int MAX_CHANNELS  = 4
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sad_disp_pix_if.sink pix,
    sad_disp_res_if.source res,
    sad_disp_cfg_if.sink cfg
);
    import sad_disp_pkg::*;

    sad_cmd_t    cmd;
    sad_status_t status;

    assign cfg.ready = 1'b1;

    sad_disp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sad_disp_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_RADIUS    (MAX_RADIUS),
        .MAX_DISPARITY (MAX_DISPARITY),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .left_pixel  (pix.left_pixel),
        .right_pixel (pix.right_pixel),
        .frame_start (pix.frame_start),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .disparity   (res.disparity),
        .match_cost  (res.match_cost),
        .column      (res.column),
        .row         (res.row),
        .frame_last  (res.frame_last)
    );

    a_issue_not_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !cmd.accept)
        else $error("scan issued while a pixel transfer is taken");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> !cmd.issue && !cmd.accept)
        else $error("scan done while scan or input still active");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> res.valid)
        else $error("result load did not raise valid");

endmodule

`default_nettype wire

// ===== hdl/sad_disp_ram.sv =====
// ----------------------------------------------------------------------------
// sad_disp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_disp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/sad_disp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sad_disp_ctrl
// Sequencer: accepts a pixel, runs the window scan, hands over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_disp_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire sad_disp_pkg::sad_status_t status,
    output sad_disp_pkg::sad_cmd_t         cmd
);
    import sad_disp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.need_result)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sad_disp_dp.sv =====
// ----------------------------------------------------------------------------
// sad_disp_dp
// Datapath: config registers, raster position, line stores, SAD accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_disp_dp #(
    parameter int MAX_WIDTH     = 2048,
    parameter int MAX_RADIUS    = 10,
    parameter int MAX_DISPARITY = 64,
    parameter int MAX_CHANNELS  = 4
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_valid,
    input  wire logic [sad_disp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sad_disp_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  wire logic [sad_disp_pkg::PIX_W-1:0]          left_pixel,
    input  wire logic [sad_disp_pkg::PIX_W-1:0]          right_pixel,
    input  wire logic                                    frame_start,
    input  wire sad_disp_pkg::sad_cmd_t                  cmd,
    output sad_disp_pkg::sad_status_t                    status,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [sad_disp_pkg::DISP_W-1:0]              disparity,
    output logic [sad_disp_pkg::COST_W-1:0]              match_cost,
    output logic [sad_disp_pkg::POS_W-1:0]               column,
    output logic [sad_disp_pkg::POS_W-1:0]               row,
    output logic                                         frame_last
);
    import sad_disp_pkg::*;

    localparam int WR     = 2 * MAX_RADIUS + 1;
    localparam int SW     = $clog2(WR);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int AW     = $clog2(WR * MAX_WIDTH);
    localparam int DW     = $clog2(MAX_DISPARITY);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int R2W    = $clog2(2 * MAX_RADIUS + 1);
    localparam int CHW    = $clog2(MAX_CHANNELS + 1);
    localparam int ACC_W  = $clog2(WR * WR * MAX_CHANNELS * 255 + 1);

    // configuration registers
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [3:0]  radius_reg;
    logic [5:0]  disp_reg;
    logic [2:0]  chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            radius_reg <= RST_RADIUS;
            disp_reg   <= RST_DISP;
            chan_reg   <= RST_CHANNELS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg  <= cfg_data;
                REG_HEIGHT:   height_reg <= cfg_data;
                REG_RADIUS:   radius_reg <= cfg_data[3:0];
                REG_DISP:     disp_reg   <= cfg_data[5:0];
                REG_CHANNELS: chan_reg   <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // clamped settings
    logic [31:0] w_c, h_c, r_c, nd_c, nc_c, r2_c;

    always_comb
    begin
        w_c  = (width_reg == '0) ? 32'd1 :
               ((32'(width_reg) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_reg));
        h_c  = (height_reg == '0) ? 32'd1 :
               ((32'(height_reg) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(height_reg));
        r_c  = (radius_reg == '0) ? 32'd1 :
               ((32'(radius_reg) > MAX_RADIUS) ? 32'(MAX_RADIUS) : 32'(radius_reg));
        nd_c = (disp_reg == '0) ? 32'd1 :
               ((32'(disp_reg) > MAX_DISPARITY) ? 32'(MAX_DISPARITY) : 32'(disp_reg));
        nc_c = (chan_reg == '0) ? 32'd1 :
               ((32'(chan_reg) > MAX_CHANNELS) ? 32'(MAX_CHANNELS) : 32'(chan_reg));
        r2_c = r_c + r_c;
    end

    // raster position
    logic [CW-1:0]    col_reg, col_next, col_cur;
    logic [POS_W-1:0] row_reg, row_next, row_cur;
    logic [SW-1:0]    wslot_reg, wslot_next, wslot_cur;

    assign col_cur   = frame_start ? '0 : col_reg;
    assign row_cur   = frame_start ? '0 : row_reg;
    assign wslot_cur = frame_start ? '0 : wslot_reg;

    always_comb
    begin
        col_next   = col_cur + 1'b1;
        row_next   = row_cur;
        wslot_next = wslot_cur;
        if (32'(col_cur) + 32'd1 >= w_c)
        begin
            col_next = '0;
            if (32'(row_cur) + 32'd1 >= h_c)
            begin
                row_next   = '0;
                wslot_next = '0;
            end
            else
            begin
                row_next   = row_cur + 1'b1;
                wslot_next = (32'(wslot_cur) == WR - 1) ? '0 : wslot_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            wslot_reg <= '0;
        end
        else if (cmd.accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            wslot_reg <= wslot_next;
        end
    end

    assign status.need_result = (32'(row_cur) >= r2_c) && (32'(row_cur) + 32'd1 <= h_c)
                             && (32'(col_cur) >= nd_c + r2_c) && (32'(col_cur) + 32'd1 <= w_c);

    // window top slot, (wslot - 2r) mod rows
    logic [SW-1:0] top_slot;
    assign top_slot = (32'(wslot_cur) >= r2_c) ? SW'(32'(wslot_cur) - r2_c)
                                               : SW'(32'(wslot_cur) + WR - r2_c);

    // scan counters and per-item settings
    logic [CW-1:0]    x_reg, xs_reg, xe_reg;
    logic [SW-1:0]    ys_reg, ts_reg;
    logic [R2W-1:0]   yc_reg, r2_reg;
    logic [DW-1:0]    d_reg, ndm1_reg;
    logic [CHW-1:0]   nc_reg;
    logic [POS_W-1:0] cx_reg, cy_reg;
    logic             last_reg;

    logic x_end, y_end, d_end, first_i;
    assign x_end   = (x_reg == xe_reg);
    assign y_end   = (yc_reg == r2_reg);
    assign d_end   = (d_reg == ndm1_reg);
    assign first_i = (yc_reg == '0) && (x_reg == xs_reg);
    assign status.issue_last = cmd.issue && x_end && y_end && d_end;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg    <= CW'(32'(col_cur) - r2_c);
            xs_reg   <= CW'(32'(col_cur) - r2_c);
            xe_reg   <= col_cur;
            ys_reg   <= top_slot;
            ts_reg   <= top_slot;
            yc_reg   <= '0;
            r2_reg   <= R2W'(r2_c);
            d_reg    <= '0;
            ndm1_reg <= DW'(nd_c - 32'd1);
            nc_reg   <= CHW'(nc_c);
            cx_reg   <= POS_W'(32'(col_cur) - r_c);
            cy_reg   <= POS_W'(32'(row_cur) - r_c);
            last_reg <= (32'(col_cur) + 32'd1 == w_c) && (32'(row_cur) + 32'd1 == h_c);
        end
        else if (cmd.issue)
        begin
            if (x_end)
            begin
                x_reg <= xs_reg;
                if (y_end)
                begin
                    yc_reg <= '0;
                    ys_reg <= ts_reg;
                    d_reg  <= d_reg + 1'b1;
                end
                else
                begin
                    yc_reg <= yc_reg + 1'b1;
                    ys_reg <= (32'(ys_reg) == WR - 1) ? '0 : ys_reg + 1'b1;
                end
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    // line stores
    logic [AW-1:0]    waddr, laddr, raddr;
    logic [PIX_W-1:0] lq, rq;

    assign waddr = AW'(32'(wslot_cur) * MAX_WIDTH + 32'(col_cur));
    assign laddr = AW'(32'(ys_reg) * MAX_WIDTH + 32'(x_reg));
    assign raddr = AW'(32'(ys_reg) * MAX_WIDTH + 32'(x_reg - CW'(d_reg)));

    sad_disp_ram #(.WIDTH(PIX_W), .DEPTH(WR * MAX_WIDTH)) u_left_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (left_pixel),
        .raddr (laddr),
        .rdata (lq)
    );

    sad_disp_ram #(.WIDTH(PIX_W), .DEPTH(WR * MAX_WIDTH)) u_right_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (right_pixel),
        .raddr (raddr),
        .rdata (rq)
    );

    // read stage flags, aligned with the registered ram data
    logic          p1_valid_reg, p1_first_reg, p1_lastd_reg, p1_fin_reg;
    logic [DW-1:0] p1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_first_reg <= first_i;
        p1_lastd_reg <= x_end && y_end;
        p1_fin_reg   <= x_end && y_end && d_end;
        p1_d_reg     <= d_reg;
    end

    // abs difference over the enabled channels
    logic [9:0]       pix_sad;
    logic [7:0]       a_b, b_b, ad;
    logic [ACC_W-1:0] acc_reg, cost_cur, best_cost_reg;
    logic [DW-1:0]    best_d_reg;
    logic             done_reg;

    always_comb
    begin
        pix_sad = '0;
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            a_b = lq[8*k +: 8];
            b_b = rq[8*k +: 8];
            ad  = (a_b > b_b) ? (a_b - b_b) : (b_b - a_b);
            if (k < int'(nc_reg))
            begin
                pix_sad = pix_sad + 10'(ad);
            end
        end
        cost_cur = (p1_first_reg ? '0 : acc_reg) + ACC_W'(pix_sad);
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            acc_reg <= cost_cur;
            if (p1_lastd_reg && (p1_d_reg == '0 || cost_cur < best_cost_reg))
            begin
                best_cost_reg <= cost_cur;
                best_d_reg    <= p1_d_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p1_valid_reg && p1_lastd_reg && p1_fin_reg;
        end
    end

    assign status.done     = done_reg;
    assign status.out_free = !out_valid || out_ready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            disparity  <= DISP_W'(best_d_reg);
            match_cost <= COST_W'(best_cost_reg);
            column     <= cx_reg;
            row        <= cy_reg;
            frame_last <= last_reg;
        end
    end

endmodule

`default_nettype wire
